// ----- design/rps_pkg.sv -----
// shared types, constants and helper functions of the reflow profile sequencer
`timescale 1ns / 1ps

package rps_pkg;

	localparam int TEMP_W   = 14;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 3;
	localparam int SEC_W    = 7;
	localparam int SOAK_W   = 5;
	localparam int REFLOW_W = 4;
	localparam int TARGET_W = 8;
	localparam int PROG_W   = 7;

	localparam logic [SEC_W-1:0]    SEC_MAX              = '1;
	localparam logic [SOAK_W-1:0]   SOAK_MAX             = '1;
	localparam logic [REFLOW_W-1:0] REFLOW_MAX           = '1;
	localparam logic [SEC_W-1:0]    PREHEAT_LIMIT_SEC    = 7'd120;
	localparam logic [SEC_W-1:0]    SOAK_LIMIT_SEC       = 7'd90;
	localparam logic [SOAK_W-1:0]   SOAK_HOLD_GOAL       = 5'd30;
	localparam logic [SEC_W-1:0]    REFLOW_LIMIT_SEC     = 7'd70;
	localparam logic [REFLOW_W-1:0] REFLOW_HOLD_GOAL     = 4'd15;
	localparam logic [SEC_W-1:0]    COOL_MIN_SEC         = 7'd20;
	localparam logic [SEC_W-1:0]    COOL_LIMIT_SEC       = 7'd120;
	localparam logic [SEC_W-1:0]    COOL_PROGRESS_SPAN_S = 7'd40;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] CFG_PREHEAT_EXIT   = 3'd0;
	localparam logic [IDX_W-1:0] CFG_SOAK_BAND_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_SOAK_BAND_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] CFG_SOAK_DECAY     = 3'd3;
	localparam logic [IDX_W-1:0] CFG_REFLOW_HOLD    = 3'd4;
	localparam logic [IDX_W-1:0] CFG_REFLOW_DECAY   = 3'd5;
	localparam logic [IDX_W-1:0] CFG_COOL_EXIT      = 3'd6;

	localparam logic [CFG_W-1:0] RST_PREHEAT_EXIT   = 13'd2320;
	localparam logic [CFG_W-1:0] RST_SOAK_BAND_LOW  = 13'd2720;
	localparam logic [CFG_W-1:0] RST_SOAK_BAND_HIGH = 13'd3040;
	localparam logic [CFG_W-1:0] RST_SOAK_DECAY     = 13'd2640;
	localparam logic [CFG_W-1:0] RST_REFLOW_HOLD    = 13'd3600;
	localparam logic [CFG_W-1:0] RST_REFLOW_DECAY   = 13'd3520;
	localparam logic [CFG_W-1:0] RST_COOL_EXIT      = 13'd1280;

	typedef enum logic [2:0] {
		STG_IDLE     = 3'd0,
		STG_PREHEAT  = 3'd1,
		STG_SOAK     = 3'd2,
		STG_REFLOW   = 3'd3,
		STG_COOL     = 3'd4,
		STG_COMPLETE = 3'd5,
		STG_FAULT    = 3'd6
	} stage_t;

	typedef struct packed {
		logic [CFG_W-1:0] preheat_exit_temp;
		logic [CFG_W-1:0] soak_band_low;
		logic [CFG_W-1:0] soak_band_high;
		logic [CFG_W-1:0] soak_decay_below;
		logic [CFG_W-1:0] reflow_hold_temp;
		logic [CFG_W-1:0] reflow_decay_below;
		logic [CFG_W-1:0] cool_exit_temp;
	} cfg_regs_t;

	typedef struct packed {
		stage_t               stage;
		logic [SEC_W-1:0]     seconds;
		logic [SOAK_W-1:0]    soak_hold;
		logic [REFLOW_W-1:0]  reflow_hold;
	} seq_state_t;

	typedef struct packed {
		logic [2:0]          stage_code;
		logic [TARGET_W-1:0] target_temp;
		logic [PROG_W-1:0]   progress_pct;
	} seq_result_t;

	function automatic logic [TARGET_W-1:0] stage_target(input stage_t st);
		logic [TARGET_W-1:0] t;
		t = '0;
		unique case (st)
			STG_PREHEAT:  t = 8'd150;
			STG_SOAK:     t = 8'd180;
			STG_REFLOW:   t = 8'd235;
			STG_COOL:     t = 8'd90;
			STG_COMPLETE: t = 8'd40;
			default:      t = '0;
		endcase
		return t;
	endfunction

	// floor(n / 3) for n below 128
	function automatic logic [5:0] div3(input logic [6:0] n);
		logic [12:0] p;
		p = 13'(n) * 13'd43;
		return p[12:7];
	endfunction

	function automatic logic [PROG_W-1:0] stage_progress(input seq_state_t s);
		logic [SEC_W-1:0]    m_sec;
		logic [9:0]          pre7;
		logic [5:0]          cool_sec;
		logic [7:0]          cool3;
		logic [SOAK_W-1:0]   m_soak;
		logic [5:0]          refl4;
		logic [PROG_W-1:0]   p;
		m_sec    = (s.seconds < PREHEAT_LIMIT_SEC) ? s.seconds : PREHEAT_LIMIT_SEC;
		// s*35/120 = (s*7/8)/3
		pre7     = 10'(m_sec) * 10'd7;
		cool_sec = (s.seconds < COOL_PROGRESS_SPAN_S) ? s.seconds[5:0]
		                                              : COOL_PROGRESS_SPAN_S[5:0];
		// s*15/40 = s*3/8
		cool3    = 8'(cool_sec) * 8'd3;
		m_soak   = (s.soak_hold < SOAK_HOLD_GOAL) ? s.soak_hold : SOAK_HOLD_GOAL;
		// h*20/15 = h*4/3
		refl4    = {s.reflow_hold, 2'b00};
		p        = '0;
		unique case (s.stage)
			STG_PREHEAT:  p = PROG_W'(div3(pre7[9:3]));
			STG_SOAK:     p = 7'd35 + PROG_W'(m_soak);
			STG_REFLOW:   p = 7'd65 + PROG_W'(div3({1'b0, refl4}));
			STG_COOL:     p = 7'd85 + PROG_W'(cool3[7:3]);
			STG_COMPLETE: p = 7'd100;
			default:      p = '0;
		endcase
		return p;
	endfunction

endpackage

// ----- design/rps_in_if.sv -----
// input item channel: measured temperature and fault flag
`timescale 1ns / 1ps

interface rps_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [rps_pkg::TEMP_W-1:0]  measured_temp;
	logic                               fault_flag;

	modport source (output valid, output measured_temp, output fault_flag, input ready);
	modport sink   (input valid, input measured_temp, input fault_flag, output ready);
endinterface

// ----- design/rps_out_if.sv -----
// result item channel: stage, target temperature and progress
`timescale 1ns / 1ps

interface rps_out_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     stage_code;
	logic [rps_pkg::TARGET_W-1:0]   target_temp;
	logic [rps_pkg::PROG_W-1:0]     progress_pct;

	modport source (output valid, output stage_code, output target_temp,
		output progress_pct, input ready);
	modport sink   (input valid, input stage_code, input target_temp,
		input progress_pct, output ready);
endinterface

// ----- design/rps_cfg_regs.sv -----
// threshold register file written through the configuration port
`timescale 1ns / 1ps

module rps_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rps_pkg::IDX_W-1:0]     cfg_index,
	input  logic [rps_pkg::CFG_W-1:0]     cfg_wdata,
	output rps_pkg::cfg_regs_t            regs
);
	import rps_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.preheat_exit_temp  <= RST_PREHEAT_EXIT;
			regs_q.soak_band_low      <= RST_SOAK_BAND_LOW;
			regs_q.soak_band_high     <= RST_SOAK_BAND_HIGH;
			regs_q.soak_decay_below   <= RST_SOAK_DECAY;
			regs_q.reflow_hold_temp   <= RST_REFLOW_HOLD;
			regs_q.reflow_decay_below <= RST_REFLOW_DECAY;
			regs_q.cool_exit_temp     <= RST_COOL_EXIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PREHEAT_EXIT:   regs_q.preheat_exit_temp  <= cfg_wdata;
				CFG_SOAK_BAND_LOW:  regs_q.soak_band_low      <= cfg_wdata;
				CFG_SOAK_BAND_HIGH: regs_q.soak_band_high     <= cfg_wdata;
				CFG_SOAK_DECAY:     regs_q.soak_decay_below   <= cfg_wdata;
				CFG_REFLOW_HOLD:    regs_q.reflow_hold_temp   <= cfg_wdata;
				CFG_REFLOW_DECAY:   regs_q.reflow_decay_below <= cfg_wdata;
				CFG_COOL_EXIT:      regs_q.cool_exit_temp     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;
endmodule

// ----- design/rps_tick_logic.sv -----
// next-state rules for one tick and the result it reports
`timescale 1ns / 1ps

module rps_tick_logic (
	input  rps_pkg::seq_state_t               cur,
	input  logic signed [rps_pkg::TEMP_W-1:0] measured_temp,
	input  logic                              fault_flag,
	input  rps_pkg::cfg_regs_t                regs,
	output rps_pkg::seq_state_t               nxt,
	output rps_pkg::seq_result_t              result
);
	import rps_pkg::*;

	logic signed [TEMP_W:0] t_ext;

	// registers are unsigned, compared against the sign-extended temperature
	function automatic logic signed [TEMP_W:0] ext_cfg(input logic [CFG_W-1:0] v);
		return $signed({{(TEMP_W + 1 - CFG_W){1'b0}}, v});
	endfunction

	assign t_ext = (TEMP_W + 1)'(measured_temp);

	always_comb begin
		logic [SEC_W-1:0]    sec_inc;
		logic [SOAK_W-1:0]   soak_new;
		logic [REFLOW_W-1:0] reflow_new;
		nxt        = cur;
		sec_inc    = (cur.seconds == SEC_MAX) ? SEC_MAX : cur.seconds + 1'b1;
		soak_new   = cur.soak_hold;
		reflow_new = cur.reflow_hold;
		if (fault_flag) begin
			nxt.stage   = STG_FAULT;
			nxt.seconds = '0;
		end else if (cur.stage != STG_COMPLETE && cur.stage != STG_FAULT) begin
			nxt.seconds = sec_inc;
			unique case (cur.stage)
				STG_PREHEAT: begin
					if (t_ext >= ext_cfg(regs.preheat_exit_temp) ||
					    sec_inc >= PREHEAT_LIMIT_SEC) begin
						nxt.stage   = STG_SOAK;
						nxt.seconds = '0;
					end
				end
				STG_SOAK: begin
					if (t_ext >= ext_cfg(regs.soak_band_low) &&
					    t_ext <= ext_cfg(regs.soak_band_high)) begin
						if (cur.soak_hold != SOAK_MAX)
							soak_new = cur.soak_hold + 1'b1;
					end else if (t_ext < ext_cfg(regs.soak_decay_below) &&
					             cur.soak_hold != '0) begin
						soak_new = cur.soak_hold - 1'b1;
					end
					nxt.soak_hold = soak_new;
					if (soak_new >= SOAK_HOLD_GOAL || sec_inc >= SOAK_LIMIT_SEC) begin
						nxt.stage   = STG_REFLOW;
						nxt.seconds = '0;
					end
				end
				STG_REFLOW: begin
					if (t_ext >= ext_cfg(regs.reflow_hold_temp)) begin
						if (cur.reflow_hold != REFLOW_MAX)
							reflow_new = cur.reflow_hold + 1'b1;
					end else if (t_ext < ext_cfg(regs.reflow_decay_below) &&
					             cur.reflow_hold != '0) begin
						reflow_new = cur.reflow_hold - 1'b1;
					end
					nxt.reflow_hold = reflow_new;
					if (reflow_new >= REFLOW_HOLD_GOAL ||
					    sec_inc >= REFLOW_LIMIT_SEC) begin
						nxt.stage   = STG_COOL;
						nxt.seconds = '0;
					end
				end
				STG_COOL: begin
					if ((t_ext <= ext_cfg(regs.cool_exit_temp) && sec_inc >= COOL_MIN_SEC) ||
					    sec_inc >= COOL_LIMIT_SEC) begin
						nxt.stage   = STG_COMPLETE;
						nxt.seconds = '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.stage_code   = nxt.stage;
	assign result.target_temp  = stage_target(nxt.stage);
	assign result.progress_pct = stage_progress(nxt);
endmodule

// ----- design/reflow_profile_sequencer_core.sv -----
// top level of the reflow profile sequencer
`timescale 1ns / 1ps

// Reflow profile sequencer. Each input item is a one-second tick carrying the
// measured oven temperature (signed, 1/16 degree) and a fault flag; each tick
// yields exactly one result item with the stage after the tick, its target
// temperature and the overall progress. The block takes one item per clock
// cycle unless out_ch.ready stalls the output; an item passes the input
// register, then the result register, as stage, seconds and hold counters
// update. Thresholds must be written through the configuration port while
// no item is in flight; the block does not enforce it. Reset restores their
// defaults and preheat. Fault holds until reset, complete until reset or fault.

module reflow_profile_sequencer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	rps_in_if.sink                    in_ch,
	rps_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [rps_pkg::IDX_W-1:0] cfg_index,
	input  logic [rps_pkg::CFG_W-1:0] cfg_wdata
);
	import rps_pkg::*;

	logic                      valid_s1;
	logic signed [TEMP_W-1:0]  temp_s1;
	logic                      fault_s1;
	logic                      out_valid_q;
	seq_result_t               result_q;
	seq_state_t                state_q;
	seq_state_t                state_nxt;
	seq_result_t               result_nxt;
	cfg_regs_t                 regs;
	logic                      adv;

	assign adv         = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	rps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.regs      (regs)
	);

	rps_tick_logic u_tick (
		.cur           (state_q),
		.measured_temp (temp_s1),
		.fault_flag    (fault_s1),
		.regs          (regs),
		.nxt           (state_nxt),
		.result        (result_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			temp_s1  <= in_ch.measured_temp;
			fault_s1 <= in_ch.fault_flag;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.stage       <= STG_PREHEAT;
			state_q.seconds     <= '0;
			state_q.soak_hold   <= '0;
			state_q.reflow_hold <= '0;
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			result_q <= result_nxt;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.stage_code   = result_q.stage_code;
	assign out_ch.target_temp  = result_q.target_temp;
	assign out_ch.progress_pct = result_q.progress_pct;
endmodule
